@@ src/fifo_with_running_maximum_assert.svh @@
// -----------------------------------------------------------------------------
// fifo_with_running_maximum_assert.svh
// Assertion macros for the queue sequencer (fwrm_ctrl); sampled on clk_i, off in reset.
// -----------------------------------------------------------------------------
`ifndef FIFO_WITH_RUNNING_MAXIMUM_ASSERT_SVH
`define FIFO_WITH_RUNNING_MAXIMUM_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define FWRM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fwrm_pkg.sv @@
// -----------------------------------------------------------------------------
// fwrm_pkg
// Types and constants for the queue with running maximum.
// -----------------------------------------------------------------------------
package fwrm_pkg;

  localparam int DataW        = 32;
  localparam int FillW        = 5;
  localparam int DefaultDepth = 16;

  localparam logic KindPush = 1'b0;
  localparam logic KindPop  = 1'b1;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic                     kind;
    logic signed [DataW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  head_value;
    logic signed [DataW-1:0]  max_value;
    logic        [FillW-1:0]  fill_count;
    logic                     is_empty;
    status_e                  status;
  } out_item_t;

endpackage

@@ src/fwrm_ram.sv @@
// -----------------------------------------------------------------------------
// fwrm_ram
// Entry store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module fwrm_ram #(
  parameter int DEPTH = fwrm_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic signed [fwrm_pkg::DataW-1:0]   wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_i,
  output logic signed [fwrm_pkg::DataW-1:0]   rdata_o
);
  import fwrm_pkg::*;

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fwrm_ctrl.sv @@
// -----------------------------------------------------------------------------
// fwrm_ctrl
// Sequencer: applies push and pop to the ring pointers, caches the head entry
// and the maximum, and reads the store after a pop to refresh them.
// -----------------------------------------------------------------------------
`include "fifo_with_running_maximum_assert.svh"

module fwrm_ctrl #(
  parameter int DEPTH = fwrm_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  fwrm_pkg::in_item_t                  in_item_i,
  output logic                                in_stall_o,
  output logic                                res_valid_o,
  output fwrm_pkg::out_item_t                 res_item_o,
  input  logic                                res_taken_i,
  output logic                                ram_we_o,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr_o,
  output logic signed [fwrm_pkg::DataW-1:0]   ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr_o,
  input  logic signed [fwrm_pkg::DataW-1:0]   ram_rdata_i
);
  import fwrm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [AW-1:0]           head_q;
  logic signed [DataW-1:0] max_q;
  logic signed [DataW-1:0] head_val_q;
  status_e                 status_q;
  logic                    rescan_q;
  logic [AW-1:0]           rp_q;
  logic [CW-1:0]           n_q;
  logic [CW-1:0]           iss_q;
  logic [CW-1:0]           rcv_q;
  logic                    rvld_q;

  logic                    accept;
  logic                    is_push;
  logic                    full;
  logic [CW:0]             tail_sum;
  logic [AW-1:0]           tail;
  logic [AW-1:0]           head_nx;
  logic [AW-1:0]           rp_nx;
  logic                    hit_max;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = (in_item_i.kind == KindPush);
  assign full       = (count_q == CW'(DEPTH));
  assign hit_max    = (head_val_q == max_q);

  // Tail slot: head plus count, wrapped once.
  always_comb begin
    tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  assign head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign rp_nx   = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);

  assign ram_we_o    = accept && is_push && !full;
  assign ram_waddr_o = tail;
  assign ram_wdata_o = in_item_i.value;
  assign ram_re_o    = (state_q == StScan) && (iss_q != n_q);
  assign ram_raddr_o = rp_q;

  assign res_valid_o           = (state_q == StEmit);
  assign res_item_o.head_value = (count_q == '0) ? '0 : head_val_q;
  assign res_item_o.max_value  = (count_q == '0) ? '0 : max_q;
  assign res_item_o.fill_count = FillW'(count_q);
  assign res_item_o.is_empty   = (count_q == '0);
  assign res_item_o.status     = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      head_q     <= '0;
      max_q      <= '0;
      head_val_q <= '0;
      status_q   <= StatusOk;
      rescan_q   <= 1'b0;
      rp_q       <= '0;
      n_q        <= '0;
      iss_q      <= '0;
      rcv_q      <= '0;
      rvld_q     <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (is_push) begin
              state_q <= StEmit;
              if (full) begin
                status_q <= StatusFull;
              end else begin
                status_q <= StatusOk;
                count_q  <= count_q + CW'(1);
                if (count_q == '0) begin
                  max_q      <= in_item_i.value;
                  head_val_q <= in_item_i.value;
                end else if (in_item_i.value > max_q) begin
                  max_q <= in_item_i.value;
                end
              end
            end else if (count_q == '0) begin
              state_q  <= StEmit;
              status_q <= StatusEmpty;
            end else begin
              status_q <= StatusOk;
              head_q   <= head_nx;
              count_q  <= count_q - CW'(1);
              if (count_q == CW'(1)) begin
                max_q   <= '0;
                state_q <= StEmit;
              end else begin
                // fetch the new head; sweep every remaining entry if the max left
                rescan_q <= hit_max;
                n_q      <= hit_max ? count_q - CW'(1) : CW'(1);
                iss_q    <= '0;
                rcv_q    <= '0;
                rp_q     <= head_nx;
                state_q  <= StScan;
              end
            end
          end
        end
        StScan: begin
          if (ram_re_o) begin
            rp_q  <= rp_nx;
            iss_q <= iss_q + CW'(1);
          end
          rvld_q <= ram_re_o;
          if (rvld_q) begin
            if (rcv_q == '0) begin
              head_val_q <= ram_rdata_i;
              if (rescan_q) begin
                max_q <= ram_rdata_i;
              end
            end else if (rescan_q && (ram_rdata_i > max_q)) begin
              max_q <= ram_rdata_i;
            end
            rcv_q <= rcv_q + CW'(1);
            if (rcv_q + CW'(1) == n_q) begin
              state_q <= StEmit;
            end
          end
        end
        StEmit: begin
          if (res_taken_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `FWRM_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "fill count beyond depth")
  `FWRM_ASSERT_ALWAYS(a_empty_max, (count_q != '0) || (max_q == '0), "max not cleared when empty")
  `FWRM_ASSERT_ALWAYS(a_rdata_in_scan, !rvld_q || (state_q == StScan), "read data outside sweep")
  `FWRM_ASSERT_NEXT(a_push_count, accept && is_push && !full, count_q == $past(count_q) + CW'(1), "push lost")

endmodule

@@ src/fifo_with_running_maximum.sv @@
// -----------------------------------------------------------------------------
// fifo_with_running_maximum
// Bounded FIFO of signed 32-bit values that reports head, maximum and fill
// after every push or pop.
// -----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_item_i  (kind, value)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (head, max, fill, ...)
//
// A push, a flagged push or a flagged pop needs no store read; a pop that leaves
// entries reads the new head, and when the maximum leaves it sweeps the N remaining
// entries through the single read port of the entry store, one entry per cycle.
// Reset clears pointers, count and maximum at once; the store needs no clearing.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only when its next result is ready.
// -----------------------------------------------------------------------------
module fifo_with_running_maximum #(
  parameter int DEPTH = fwrm_pkg::DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fwrm_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fwrm_pkg::out_item_t  out_item_o
);
  import fwrm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic signed [DataW-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic signed [DataW-1:0] ram_rdata;
  logic                    res_valid;
  out_item_t               res_item;
  logic                    res_load;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  fwrm_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fwrm_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_taken_i (res_load),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Load the output register when it is empty or its transfer completes now.
  assign res_load = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ bench/fifo_with_running_maximum_checker.sv @@
// -----------------------------------------------------------------------------
// fifo_with_running_maximum_checker
// Watches both channels of the max queue. It keeps its own copy of the ring
// and the running maximum, predicts one result per input transfer, and
// compares each output transfer field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module fifo_with_running_maximum_checker #(
  parameter int DEPTH = fwrm_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  fwrm_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  fwrm_pkg::out_item_t out_item_i,
  output int                  in_flight_o,
  output int                  mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fwrm_pkg::*;

  logic signed [DataW-1:0] ring [DEPTH];
  int unsigned             ring_head;
  int unsigned             ring_fill;
  logic signed [DataW-1:0] peak;

  out_item_t predicted_results [$];
  int        mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic out_item_t apply_queue_op(in_item_t op);
    out_item_t               res;
    status_e                 st;
    logic signed [DataW-1:0] gone;
    logic signed [DataW-1:0] best;
    st = StatusOk;
    if (op.kind == KindPush) begin
      if (ring_fill == DEPTH) begin
        st = StatusFull;
      end else begin
        ring[(ring_head + ring_fill) % DEPTH] = op.value;
        if (ring_fill == 0 || op.value > peak) begin
          peak = op.value;
        end
        ring_fill++;
      end
    end else if (ring_fill == 0) begin
      st = StatusEmpty;
    end else begin
      gone      = ring[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
      if (ring_fill == 0) begin
        peak = '0;
      end else if (gone == peak) begin
        // the maximum left: sweep what remains
        best = ring[ring_head];
        for (int i = 1; i < ring_fill; i++) begin
          if (ring[(ring_head + i) % DEPTH] > best) begin
            best = ring[(ring_head + i) % DEPTH];
          end
        end
        peak = best;
      end
    end
    res.head_value = (ring_fill == 0) ? '0 : ring[ring_head];
    res.max_value  = (ring_fill == 0) ? '0 : peak;
    res.fill_count = ring_fill[FillW-1:0];
    res.is_empty   = (ring_fill == 0);
    res.status     = st;
    return res;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (predicted_results.size() == 0) begin
      $error("unexpected result transfer: head_value %0d max_value %0d fill_count %0d",
             got.head_value, got.max_value, got.fill_count);
      mismatches++;
      return;
    end
    want = predicted_results.pop_front();
    if (got.head_value !== want.head_value) begin
      $error("head_value: expected %0d, got %0d", want.head_value, got.head_value);
      mismatches++;
    end
    if (got.max_value !== want.max_value) begin
      $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
      mismatches++;
    end
    if (got.fill_count !== want.fill_count) begin
      $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
      mismatches++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_results.delete();
      ring_head = 0;
      ring_fill = 0;
      peak      = '0;
      in_flight_o <= 0;
    end else begin
      // a result never leaves in the cycle its item arrives: compare first
      if (out_valid_i && !out_stall_i) begin
        check_result(out_item_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_results.push_back(apply_queue_op(in_item_i));
      end
      in_flight_o <= predicted_results.size();
    end
  end

endmodule

@@ bench/fifo_with_running_maximum_tb.sv @@
// -----------------------------------------------------------------------------
// fifo_with_running_maximum_tb
// Drives push and pop transfers into the max queue with random gaps and
// output stalls; the checker beside the block predicts and compares results.
// -----------------------------------------------------------------------------
module fifo_with_running_maximum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwrm_pkg::*;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  int        in_flight;
  int        mismatches;

  logic calm  = 1'b0;
  logic gappy = 1'b1;
  int   push_count = 0;
  int   pop_count  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fifo_with_running_maximum #(.DEPTH(DefaultDepth)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  fifo_with_running_maximum_checker #(.DEPTH(DefaultDepth)) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .in_flight_o  (in_flight),
    .mismatches_o (mismatches)
  );

  task automatic transfer_op(input logic op_kind, input logic signed [DataW-1:0] op_value);
    in_item  <= '{kind: op_kind, value: op_value};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (op_kind == KindPush) begin
      push_count++;
    end else begin
      pop_count++;
    end
  endtask

  task automatic maybe_pause();
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'sd4 - 32'($urandom_range(0, 8));
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - 32'($urandom_range(0, 2))
                                     : 32'sh8000_0000 + 32'($urandom_range(0, 2));
      default: return $urandom;
    endcase
  endfunction

  // output stall in random bursts, quiet once the run winds down
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 10);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 4) == 0) run = $urandom_range(20, 40);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin
    int   mode;
    int   push_pct;
    logic op_kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pop, extremes, a tie with the maximum, emptying again
    transfer_op(KindPop, 32'sd0);
    transfer_op(KindPush, 32'sh7FFF_FFFF);
    transfer_op(KindPush, 32'sh8000_0000);
    transfer_op(KindPush, 32'sh7FFF_FFFF);
    transfer_op(KindPop, '1);
    transfer_op(KindPop, 32'sh8000_0000);
    transfer_op(KindPop, 32'sh7FFF_FFFF);
    transfer_op(KindPop, 32'sd0);
    // fill with falling values so that popping them rescans until larger values arrive
    for (int i = 0; i < DefaultDepth; i++) begin
      transfer_op(KindPush, 32'sd7 - 32'(i));
      maybe_pause();
    end
    transfer_op(KindPush, 32'sh5A5A_A5A5);

    for (int n = 0; n < 575; n++) begin
      if (n % 40 == 0) begin
        mode  = $urandom_range(0, 2);
        gappy = ($urandom_range(0, 3) != 0);
      end
      if (n == 200 || n == 400) wait_for_drain();
      if (n == 515) calm = 1'b1;
      case (mode)
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 55;
      endcase
      op_kind = ($urandom_range(0, 99) < push_pct) ? KindPush : KindPop;
      transfer_op(op_kind, pick_value());
      maybe_pause();
    end

    wait_for_drain();
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d push and %0d pop transfers through full and empty queues,",
             push_count, pop_count);
    $display("with tied and extreme values, maximum rescans, sender gaps and output stalls.");
    if (mismatches == 0 && in_flight == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
